/* rtl/dogx_pkg.sv */
// Shared types and constants of the DoG extremum and edge detector.
`default_nettype none
package dogx_pkg;

    localparam int MaxWidth   = 1024;
    localparam int SampleBits = 16;
    localparam int ColBits    = $clog2(MaxWidth);
    localparam int CntBits    = 10;
    localparam int CfgBits    = 15;
    localparam int MaxHeight  = 1024;
    localparam int DBits      = SampleBits + 4;
    localparam int PBits      = 2 * DBits + 8;

    localparam logic [1:0] RegWidth     = 2'd0;
    localparam logic [1:0] RegHeight    = 2'd1;
    localparam logic [1:0] RegThreshold = 2'd2;

    typedef logic signed [SampleBits-1:0] sample_t;
    typedef sample_t [26:0] window_t;

    typedef struct packed {
        sample_t    lower_sample;
        sample_t    centre_sample;
        sample_t    upper_sample;
        logic       frame_start;
    } in_item_t;

    typedef struct packed {
        logic               is_keypoint;
        logic               is_maximum;
        logic [CntBits-1:0] centre_x;
        logic [CntBits-1:0] centre_y;
        logic               window_valid;
    } out_item_t;

    // Position tag that travels with each window
    typedef struct packed {
        logic               valid;
        logic [CntBits-1:0] x;
        logic [CntBits-1:0] y;
    } pos_t;

endpackage
`default_nettype wire

/* rtl/dogx_window.sv */
// Raster position, line store and 3x3x3 window; one pixel in per transfer.
`default_nettype none
module dogx_window (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         en,
    input  wire logic                         acc,
    input  wire dogx_pkg::in_item_t           item,
    input  wire logic [10:0]                  frame_width,
    input  wire logic [10:0]                  frame_height,
    output dogx_pkg::window_t                 win,
    output dogx_pkg::pos_t                    pos,
    output logic                              busy
);
    localparam int Cb = dogx_pkg::ColBits;
    localparam int Sb = dogx_pkg::SampleBits;
    localparam int Nb = dogx_pkg::CntBits;

    logic [Nb-1:0] column_count_reg, row_count_reg;
    logic [Nb-1:0] column_count_next, row_count_next;
    logic [Nb-1:0] x, y, yn;
    logic [10:0] xn;
    logic [10:0] w, h;
    logic [Cb-1:0] addr;
    dogx_pkg::window_t win_reg, win_next;
    dogx_pkg::pos_t pos_reg;

    // Read stage: accepted pixel, its position and the line store word
    logic               s0_vld_reg;
    dogx_pkg::in_item_t s0_item_reg;
    logic [Nb-1:0]      s0_x_reg, s0_y_reg;

    // Line store: rows y-1 and y-2 of all three planes in one word
    logic [6*Sb-1:0] line_mem [dogx_pkg::MaxWidth];
    logic [6*Sb-1:0] rd_reg;
    logic [6*Sb-1:0] wdata;
    logic            fwd;

    // Zero the line store once after reset, one entry per cycle
    logic          clearing_reg;
    logic [Cb-1:0] clr_addr_reg;

    // Clamp geometry and derive the current position
    always_comb
    begin
        w = frame_width;
        h = frame_height;
        if (w < 11'd3) w = 11'd3;
        if (w > 11'(dogx_pkg::MaxWidth)) w = 11'(dogx_pkg::MaxWidth);
        if (h < 11'd3) h = 11'd3;
        if (h > 11'(dogx_pkg::MaxHeight)) h = 11'(dogx_pkg::MaxHeight);
        x = item.frame_start ? '0 : column_count_reg;
        y = item.frame_start ? '0 : row_count_reg;
        if ({1'b0, x} >= w)
        begin
            x = '0;
            y = y + 1'b1;
        end
        if ({1'b0, y} >= h) y = '0;
        xn = {1'b0, x} + 11'd1;
        yn = y;
        if (xn >= w)
        begin
            xn = '0;
            yn = y + 1'b1;
            if ({1'b0, yn} >= h) yn = '0;
        end
        column_count_next = xn[Nb-1:0];
        row_count_next = yn;
        addr = x[Cb-1:0];
    end

    // Newer row moves to the older half, incoming pixel becomes the newer row
    assign wdata = {rd_reg[0 +: 3*Sb], s0_item_reg.upper_sample,
                    s0_item_reg.centre_sample, s0_item_reg.lower_sample};

    // Take the pending write when the same column is read again
    assign fwd = s0_vld_reg && (s0_x_reg == x);

    // Shift the window: columns from line store and the incoming pixel
    always_comb
    begin
        sample_col_t:
        for (int p = 0; p < 3; p++)
        begin
            win_next[p*9+0] = win_reg[p*9+1];
            win_next[p*9+1] = win_reg[p*9+2];
            win_next[p*9+3] = win_reg[p*9+4];
            win_next[p*9+4] = win_reg[p*9+5];
            win_next[p*9+6] = win_reg[p*9+7];
            win_next[p*9+7] = win_reg[p*9+8];
        end
        win_next[2]  = rd_reg[3*Sb +: Sb];
        win_next[5]  = rd_reg[0    +: Sb];
        win_next[8]  = s0_item_reg.lower_sample;
        win_next[11] = rd_reg[4*Sb +: Sb];
        win_next[14] = rd_reg[Sb   +: Sb];
        win_next[17] = s0_item_reg.centre_sample;
        win_next[20] = rd_reg[5*Sb +: Sb];
        win_next[23] = rd_reg[2*Sb +: Sb];
        win_next[26] = s0_item_reg.upper_sample;
    end

    // Line store: clear, write back and registered read
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
            line_mem[clr_addr_reg] <= '0;
        else if (en && s0_vld_reg)
            line_mem[s0_x_reg[Cb-1:0]] <= wdata;
        if (acc)
            rd_reg <= fwd ? wdata : line_mem[addr];
    end

    // Hold the accepted pixel for the read stage
    always_ff @(posedge clk)
    begin
        if (acc)
            s0_item_reg <= item;
    end

    // Hold counters, window and position tag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
            s0_vld_reg       <= 1'b0;
            s0_x_reg         <= '0;
            s0_y_reg         <= '0;
            win_reg          <= '0;
            pos_reg          <= '0;
            clearing_reg     <= 1'b1;
            clr_addr_reg     <= '0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == Cb'(dogx_pkg::MaxWidth - 1))
                    clearing_reg <= 1'b0;
            end
            if (acc)
            begin
                column_count_reg <= column_count_next;
                row_count_reg    <= row_count_next;
                s0_x_reg         <= x;
                s0_y_reg         <= y;
            end
            if (en)
            begin
                s0_vld_reg    <= acc;
                pos_reg.valid <= s0_vld_reg && (s0_x_reg >= Nb'(2)) && (s0_y_reg >= Nb'(2));
                pos_reg.x     <= s0_x_reg - 1'b1;
                pos_reg.y     <= s0_y_reg - 1'b1;
                if (s0_vld_reg)
                    win_reg <= win_next;
            end
        end
    end

    assign win  = win_reg;
    assign pos  = pos_reg;
    assign busy = clearing_reg;

    // Column counter stays below the maximum width
    assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, column_count_reg} < 11'(dogx_pkg::MaxWidth))
        else $error("column count out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        acc |-> !clearing_reg)
        else $error("pixel taken while clearing");
    assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !s0_vld_reg)
        else $error("read stage busy while clearing");
endmodule
`default_nettype wire

/* rtl/dogx_test.sv */
// Contrast, extremum and edge tests over three pipeline stages.
`default_nettype none
module dogx_test (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire dogx_pkg::window_t     win,
    input  wire dogx_pkg::pos_t        pos,
    input  wire logic [14:0]           contrast_threshold,
    output dogx_pkg::out_item_t        result
);
    localparam int Db = dogx_pkg::DBits;
    localparam int Pb = dogx_pkg::PBits;
    typedef logic signed [Db-1:0] d_t;
    typedef logic signed [Pb-1:0] p_t;

    // Stage A: comparisons and second differences
    logic signed [dogx_pkg::SampleBits:0] mag;
    logic ismax, ext;
    d_t dxx_n, dyy_n, dxy_n;
    logic a_pass_reg, a_max_reg;
    d_t dxx_reg, dyy_reg, dxy_reg;
    dogx_pkg::pos_t a_pos_reg, b_pos_reg;

    always_comb
    begin
        mag = win[13][dogx_pkg::SampleBits-1] ? -(Db-3)'(win[13]) : (Db-3)'(win[13]);
        ismax = win[13] > win[22];
        ext = 1'b1;
        for (int k = 0; k < 27; k++)
        begin
            if (ismax ? (win[13] < win[k]) : (win[13] > win[k])) ext = 1'b0;
        end
        dxx_n = 4 * (d_t'(win[14]) + d_t'(win[12]) - 2 * d_t'(win[13]));
        dyy_n = 4 * (d_t'(win[16]) + d_t'(win[10]) - 2 * d_t'(win[13]));
        dxy_n = d_t'(win[17]) + d_t'(win[9]) - d_t'(win[11]) - d_t'(win[15]);
    end

    // Stage B: products
    p_t pxx_reg, pxy_reg, ptt_reg;
    logic b_pass_reg, b_max_reg;
    logic signed [Db:0] tr;
    assign tr = (Db+1)'(dxx_reg) + (Db+1)'(dyy_reg);

    // Stage C: compare det and edge ratio
    logic c_key;
    p_t det;
    assign det = pxx_reg - pxy_reg;
    assign c_key = b_pass_reg && (det > 0) && (10 * ptt_reg < 121 * det);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_pos_reg <= '0;
            b_pos_reg <= '0;
            result    <= '0;
        end
        else if (en)
        begin
            a_pos_reg <= pos;
            b_pos_reg <= a_pos_reg;
            result.is_keypoint  <= b_pos_reg.valid & c_key;
            result.is_maximum   <= b_pos_reg.valid & b_max_reg;
            result.centre_x     <= b_pos_reg.valid ? b_pos_reg.x : '0;
            result.centre_y     <= b_pos_reg.valid ? b_pos_reg.y : '0;
            result.window_valid <= b_pos_reg.valid;
        end
    end

    // Payload stages without reset
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_pass_reg <= pos.valid && ext && (mag > $signed({2'b0, contrast_threshold}));
            a_max_reg  <= ismax;
            dxx_reg    <= dxx_n;
            dyy_reg    <= dyy_n;
            dxy_reg    <= dxy_n;
            pxx_reg    <= p_t'(dxx_reg) * p_t'(dyy_reg);
            pxy_reg    <= p_t'(dxy_reg) * p_t'(dxy_reg);
            ptt_reg    <= p_t'(tr) * p_t'(tr);
            b_pass_reg <= a_pass_reg;
            b_max_reg  <= a_max_reg;
        end
    end

    // A keypoint only appears on a valid window
    assert property (@(posedge clk) disable iff (!rst_n)
        result.is_keypoint |-> result.window_valid)
        else $error("keypoint outside window");
    assert property (@(posedge clk) disable iff (!rst_n)
        !result.window_valid |-> (result.centre_x == '0 && !result.is_maximum))
        else $error("invalid result not cleared");
    assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(result))
        else $error("result moved during stall");
endmodule
`default_nettype wire

/* rtl/dog_extremum_edge_detector_core.sv */
// Top level of the DoG extremum and edge detector.
// One pixel per cycle with back-to-back transfers; a result is presented once its pixel's
// transfer has passed the line store read stage, the window stage, two test stages and
// the output register, and the whole pipe advances only while the output is free
// or taken. After reset in_ready stays low while the line store is cleared to zero,
// one entry per cycle.
`default_nettype none
module dog_extremum_edge_detector_core (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire dogx_pkg::in_item_t   in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output dogx_pkg::out_item_t       out_data,
    input  wire logic                 cfg_we,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [14:0]          cfg_data
);
    logic [10:0] frame_width_reg, frame_height_reg;
    logic [14:0] contrast_threshold_reg;
    logic [4:0]  vld_reg;
    logic        en;
    logic        acc;
    logic        busy;
    dogx_pkg::window_t win;
    dogx_pkg::pos_t    pos;

    // Advance when the last stage is empty or being taken
    assign en        = !vld_reg[4] || out_ready;
    assign in_ready  = en && !busy;
    assign acc       = in_valid && in_ready;
    assign out_valid = vld_reg[4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg        <= 11'd640;
            frame_height_reg       <= 11'd480;
            contrast_threshold_reg <= 15'd256;
            vld_reg                <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    dogx_pkg::RegWidth:     frame_width_reg <= cfg_data[10:0];
                    dogx_pkg::RegHeight:    frame_height_reg <= cfg_data[10:0];
                    dogx_pkg::RegThreshold: contrast_threshold_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (en) vld_reg <= {vld_reg[3:0], acc};
        end
    end

    dogx_window u_window (
        .clk, .rst_n, .en, .acc, .item(in_data),
        .frame_width(frame_width_reg), .frame_height(frame_height_reg),
        .win, .pos, .busy
    );

    dogx_test u_test (
        .clk, .rst_n, .en,
        .win, .pos, .contrast_threshold(contrast_threshold_reg), .result(out_data)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("accepted while output stalled");
endmodule
`default_nettype wire

/* bench/dog_extremum_edge_detector_core_test.sv */
// Self-checking testbench for the DoG extremum and edge detector core.
`timescale 1ns / 100ps
`default_nettype none
module dog_extremum_edge_detector_core_test;

    localparam int CycleLimit = 400000;
    localparam int DirRows    = 16;
    localparam int Phases     = 7;

    typedef struct {
        dogx_pkg::in_item_t  px;
        dogx_pkg::out_item_t want;
    } dir_row_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    dogx_pkg::in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    dogx_pkg::out_item_t out_data;
    logic      cfg_we;
    logic [1:0]  cfg_index;
    logic [14:0] cfg_data;

    // predictor state
    int unsigned width_reg;
    int unsigned height_reg;
    int unsigned thresh_reg;
    int          line_mem [2*dogx_pkg::MaxWidth][3];
    int          win [27];
    int unsigned col_pos;
    int unsigned row_pos;

    dogx_pkg::out_item_t detect_q [$];
    int          errors;
    int          cycles;
    int          burst_left;

    dog_extremum_edge_detector_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // bound the run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver stalls: four stall modes taken in turn
    always @(posedge clk)
    begin
        case ((cycles / 64) % 4)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            2: out_ready <= (cycles % 5 != 0);
            default: out_ready <= $urandom_range(0, 1);
        endcase
    end

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        errors++;
    endtask

    // compare each transfer with the oldest expectation
    always @(posedge clk)
    begin
        dogx_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (detect_q.size() == 0)
                report("unexpected result", 1, 0);
            else
            begin
                want = detect_q.pop_front();
                if (out_data.is_keypoint !== want.is_keypoint)
                    report("is_keypoint", out_data.is_keypoint, want.is_keypoint);
                if (out_data.is_maximum !== want.is_maximum)
                    report("is_maximum", out_data.is_maximum, want.is_maximum);
                if (out_data.centre_x !== want.centre_x)
                    report("centre_x", out_data.centre_x, want.centre_x);
                if (out_data.centre_y !== want.centre_y)
                    report("centre_y", out_data.centre_y, want.centre_y);
                if (out_data.window_valid !== want.window_valid)
                    report("window_valid", out_data.window_valid, want.window_valid);
            end
        end
    end

    function automatic longint plane_at(int r, int c);
        return win[9 + r*3 + c];
    endfunction

    // shift window and line store, then run contrast, extremum and edge tests
    function automatic dogx_pkg::out_item_t detect(dogx_pkg::in_item_t px);
        int unsigned w, h, x, y;
        int          cur [3];
        int          column [3];
        int          b;
        bit          ok, key, ismax, ext;
        longint      c, mag, dxx, dyy, dxy, tr;
        dogx_pkg::out_item_t o;
        w = width_reg < 3 ? 3 :
            (width_reg > dogx_pkg::MaxWidth ? dogx_pkg::MaxWidth : width_reg);
        h = height_reg < 3 ? 3 :
            (height_reg > dogx_pkg::MaxHeight ? dogx_pkg::MaxHeight : height_reg);
        if (px.frame_start)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        x = col_pos;
        y = row_pos;
        if (x >= w)
        begin
            x = 0;
            y++;
        end
        if (y >= h)
            y = 0;
        cur[0] = px.lower_sample;
        cur[1] = px.centre_sample;
        cur[2] = px.upper_sample;
        for (int p = 0; p < 3; p++)
        begin
            column[0] = line_mem[dogx_pkg::MaxWidth + x][p];
            column[1] = line_mem[x][p];
            column[2] = cur[p];
            for (int r = 0; r < 3; r++)
            begin
                b = p*9 + r*3;
                win[b]     = win[b+1];
                win[b+1]   = win[b+2];
                win[b+2]   = column[r];
            end
            line_mem[dogx_pkg::MaxWidth + x][p] = line_mem[x][p];
            line_mem[x][p] = cur[p];
        end
        ok = (x >= 2) && (y >= 2);
        key = 1'b0;
        ismax = 1'b0;
        if (ok)
        begin
            c = win[13];
            mag = c < 0 ? -c : c;
            ismax = c > win[22];
            ext = 1'b1;
            for (int k = 0; k < 27; k++)
                if (ismax ? (c < win[k]) : (c > win[k]))
                    ext = 1'b0;
            if (mag > thresh_reg && ext)
            begin
                dxx = 4 * (plane_at(1, 2) + plane_at(1, 0) - 2*c);
                dyy = 4 * (plane_at(2, 1) + plane_at(0, 1) - 2*c);
                dxy = plane_at(2, 2) + plane_at(0, 0) - plane_at(0, 2) - plane_at(2, 0);
                tr = dxx + dyy;
                key = (dxy*dxy < dxx*dyy) && (10*tr*tr < 121*dxx*dyy - 121*dxy*dxy);
            end
        end
        o.is_keypoint  = key;
        o.is_maximum   = ok && ismax;
        o.centre_x     = ok ? dogx_pkg::CntBits'(x - 1) : '0;
        o.centre_y     = ok ? dogx_pkg::CntBits'(y - 1) : '0;
        o.window_valid = ok;
        // advance position, wrap at frame end
        x++;
        if (x >= w)
        begin
            x = 0;
            y++;
            if (y >= h)
                y = 0;
        end
        col_pos = x;
        row_pos = y;
        return o;
    endfunction

    // hand one pixel over in bursts with random gaps
    task automatic send_pixel(dogx_pkg::in_item_t px, bit typed, dogx_pkg::out_item_t want);
        dogx_pkg::out_item_t pred;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 2) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= px;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pred = detect(px);
        detect_q.insert(detect_q.size(), typed ? want : pred);
    endtask

    // write all three registers while the core is idle
    task automatic write_regs(int unsigned w, int unsigned h, int unsigned t);
        cfg_we    <= 1'b1;
        cfg_index <= dogx_pkg::RegWidth;
        cfg_data  <= 15'(w);
        @(posedge clk);
        cfg_index <= dogx_pkg::RegHeight;
        cfg_data  <= 15'(h);
        @(posedge clk);
        cfg_index <= dogx_pkg::RegThreshold;
        cfg_data  <= 15'(t);
        @(posedge clk);
        cfg_we <= 1'b0;
        width_reg  = w & 16'h7FF;
        height_reg = h & 16'h7FF;
        thresh_reg = t & 16'h7FFF;
    endtask

    function automatic dogx_pkg::sample_t small_noise();
        return dogx_pkg::sample_t'(int'($urandom_range(0, 64)) - 32);
    endfunction

    // mostly smooth planes with isolated peaks and pits; some raw noise
    function automatic dogx_pkg::in_item_t make_pixel();
        dogx_pkg::in_item_t px;
        int unsigned pick;
        pick = $urandom_range(0, 15);
        if (pick == 0)
        begin
            px.lower_sample  = dogx_pkg::sample_t'($urandom);
            px.centre_sample = dogx_pkg::sample_t'($urandom);
            px.upper_sample  = dogx_pkg::sample_t'($urandom);
        end
        else
        begin
            px.lower_sample  = small_noise();
            px.upper_sample  = small_noise();
            if (pick <= 2)
                px.centre_sample = dogx_pkg::sample_t'(int'($urandom_range(300, 32767)));
            else if (pick <= 4)
                px.centre_sample = dogx_pkg::sample_t'(-int'($urandom_range(300, 32768)));
            else
                px.centre_sample = small_noise();
        end
        px.frame_start = ($urandom_range(0, 60) == 0);
        return px;
    endfunction

    task automatic wait_drained();
        while (detect_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    initial
    begin
        dir_row_t    rows [DirRows];
        int unsigned ph_w [Phases];
        int unsigned ph_h [Phases];
        int unsigned ph_t [Phases];
        int          count;

        ph_w = '{3, 5, 0, 2047, 8, 16, 7};
        ph_h = '{3, 4, 1, 2047, 6, 8, 5};
        ph_t = '{0, 256, 32767, 100, 50, 200, 0};

        // row 0 of a 640-wide frame: the window is never valid yet
        rows = '{
            '{'{16'sh8000, 16'sh8000, 16'sh8000, 1'b1}, '0},
            '{'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0}, '0},
            '{'{16'sh0000, 16'sh0000, 16'sh0000, 1'b0}, '0},
            '{'{16'shFFFF, 16'shFFFF, 16'shFFFF, 1'b0}, '0},
            '{'{16'sh7FFF, 16'sh8000, 16'sh0001, 1'b0}, '0},
            '{'{16'sh8000, 16'sh7FFF, 16'shFFFF, 1'b0}, '0},
            '{'{16'sh5555, 16'shAAAA, 16'sh5555, 1'b0}, '0},
            '{'{16'shAAAA, 16'sh5555, 16'shAAAA, 1'b0}, '0},
            '{'{16'sh0100, 16'sh0101, 16'sh00FF, 1'b1}, '0},
            '{'{16'shFF00, 16'shFEFF, 16'shFF01, 1'b0}, '0},
            '{'{16'sh0000, 16'sh7FFF, 16'sh0000, 1'b0}, '0},
            '{'{16'sh0000, 16'sh8000, 16'sh0000, 1'b0}, '0},
            '{'{16'sh1234, 16'sh4321, 16'shF0F0, 1'b0}, '0},
            '{'{16'sh0F0F, 16'shEDCB, 16'sh8001, 1'b0}, '0},
            '{'{16'sh7FFE, 16'sh0001, 16'sh8000, 1'b1}, '0},
            '{'{16'shFFFE, 16'sh0002, 16'sh7FFF, 1'b0}, '0}
        };

        // hold every input known through reset
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        out_ready  = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = dogx_pkg::RegWidth;
        cfg_data   = '0;
        cycles     = 0;
        errors     = 0;
        burst_left = 0;
        width_reg  = 640;
        height_reg = 480;
        thresh_reg = 256;
        col_pos    = 0;
        row_pos    = 0;
        foreach (win[k])
            win[k] = 0;
        foreach (line_mem[i, p])
            line_mem[i][p] = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows under the reset configuration
        for (int i = 0; i < DirRows; i++)
            send_pixel(rows[i].px, 1'b1, rows[i].want);
        in_valid <= 1'b0;
        wait_drained();

        // random phases; counters carry over so a reduced size is hit mid-row
        for (int ph = 0; ph < Phases; ph++)
        begin
            write_regs(ph_w[ph], ph_h[ph], ph_t[ph]);
            count = (ph_w[ph] > 1000) ? 40 : 85;
            for (int n = 0; n < count; n++)
                send_pixel(make_pixel(), 1'b0, '0);
            in_valid <= 1'b0;
            wait_drained();
        end

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
`default_nettype wire

/* sim.f */
rtl/dogx_pkg.sv
rtl/dogx_window.sv
rtl/dogx_test.sv
rtl/dog_extremum_edge_detector_core.sv
bench/dog_extremum_edge_detector_core_test.sv
